// ===== hdl/pwc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants of the protein word classifier.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam logic [2:0] OP_LETTER = 3'd0;
  localparam logic [2:0] OP_MAP    = 3'd1;
  localparam logic [2:0] OP_WORD   = 3'd2;
  localparam logic [2:0] OP_LOW    = 3'd3;
  localparam logic [2:0] OP_HIGH   = 3'd4;
  localparam logic [2:0] OP_WEIGHT = 3'd5;

  localparam int unsigned ALPHA        = 20;
  localparam int unsigned WORD_LETTERS = 12;
  localparam int unsigned WINDOW       = 18;
  localparam int unsigned HEX_SPAN     = 3200000;
  localparam int unsigned BOUND_DEPTH  = 64000000;
  localparam int unsigned WEIGHT_DEPTH = WORD_LETTERS * ALPHA * ALPHA;
  localparam int unsigned MAP_DEPTH    = 128;
  localparam logic [4:0]  MAP_INVALID  = 5'd31;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MAP   = 11'b00000000010,
    ST_BOUND = 11'b00000000100,
    ST_BWAIT = 11'b00000001000,
    ST_PROBE = 11'b00000010000,
    ST_PWAIT = 11'b00000100000,
    ST_WORDS = 11'b00001000000,
    ST_WWAIT = 11'b00010000000,
    ST_SCORE = 11'b00100000000,
    ST_SWAIT = 11'b01000000000,
    ST_EMIT  = 11'b10000000000
  } state_t;

endpackage

// ===== hdl/protein_word_classifier.sv =====
// ----------------------------------------------------------------------------
// protein_word_classifier
// Classifies 12-letter protein words against a sorted reference table.
// ----------------------------------------------------------------------------
// Usage: raise start with op, addr, value and weight while busy is low; the
// transaction is taken at that edge. Write ops (letter map, word, bounds,
// weights) are written at that edge and give no result. A letter op goes through
// the registered letter map. Once 18 valid letters stand in the window, the
// block reads the hexamer bounds, binary searches the word memory with one
// registered memory read per probe, then reads both neighbour words and
// scores them by 24 reads of the weight memory. It then emits 12 result
// transactions on consecutive cycles, marked by strobe, newest position
// first, with last on the twelfth. The receiver cannot stall: each result
// stands for exactly one cycle. Reset clears the window, the letter counter
// and the letter map valid bits; the word, bound and weight memories keep
// their contents and must be written before they are read.
// ----------------------------------------------------------------------------
module protein_word_classifier #(
  parameter int unsigned TABLE_WORDS = 1048576
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [25:0]        addr,
  input  logic [59:0]        value,
  input  logic signed [15:0] weight,
  output logic               strobe,
  output logic [31:0]        seq_pos,
  output logic [19:0]        match_index,
  output logic signed [19:0] total_score,
  output logic [3:0]         position,
  output logic signed [15:0] pos_score,
  output logic               last
);

  localparam int unsigned TW_BITS = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;

  pwc_pkg::state_t state;

  // Memories. The letter map carries a valid bit per entry so that reset
  // makes every character invalid at once.
  logic [4:0]         map_mem [pwc_pkg::MAP_DEPTH];
  logic [pwc_pkg::MAP_DEPTH-1:0] map_valid;
  logic [59:0]        word_mem [TABLE_WORDS];
  logic [19:0]        low_mem  [pwc_pkg::BOUND_DEPTH];
  logic [19:0]        high_mem [pwc_pkg::BOUND_DEPTH];
  logic signed [15:0] wt_mem   [pwc_pkg::WEIGHT_DEPTH];

  logic [4:0]         map_rd;
  logic               map_rd_valid;
  logic [59:0]        word_rd;
  logic [19:0]        low_rd, high_rd;
  logic signed [15:0] wt_rd;

  // Window state.
  logic [59:0] recent_word;
  logic [29:0] hex_word;
  logic [25:0] hex_index;
  logic [4:0]  valid_count;
  logic [31:0] letter_counter;
  logic [31:0] word_start;
  logic        map_oob;

  // Search and scoring state.
  logic [19:0] lo, up;
  logic [59:0] lo_word, up_word;
  logic [3:0]  pidx;
  logic        which;
  logic signed [19:0] lo_sum, up_sum;
  logic signed [15:0] lo_w [pwc_pkg::WORD_LETTERS];
  logic signed [15:0] up_w [pwc_pkg::WORD_LETTERS];
  logic        win_up;

  // Read address chosen by the sequencer.
  logic [25:0] word_raddr;
  logic        word_rok;
  logic [12:0] wt_raddr;
  logic        wt_rok;

  logic        take;
  assign take = start && !busy;
  assign busy = (state != pwc_pkg::ST_IDLE);

  logic [20:0] piv_sum;
  logic [19:0] piv;
  assign piv_sum = {1'b0, up} + {1'b0, lo};
  assign piv     = piv_sum[20:1];

  // Weight index for the current position of the current neighbour.
  logic [59:0] nb_word;
  logic [4:0]  row, col;
  logic [13:0] wt_index;
  assign nb_word  = which ? up_word : lo_word;
  assign row      = recent_word[5*pidx +: 5];
  assign col      = nb_word[5*pidx +: 5];
  assign wt_index = 14'(pidx) * 14'd400 + 14'(col) * 14'd20 + 14'(row);

  always_comb begin
    word_raddr = 26'(piv);
    if (state == pwc_pkg::ST_WORDS) word_raddr = 26'(which ? up : lo);
    word_rok = (32'(word_raddr) < TABLE_WORDS);
    wt_rok   = (wt_index < 14'(pwc_pkg::WEIGHT_DEPTH));
    wt_raddr = wt_index[12:0];
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (take && op == pwc_pkg::OP_WORD && 32'(addr) < TABLE_WORDS)
      word_mem[addr[TW_BITS-1:0]] <= value;
    if (take && op == pwc_pkg::OP_LOW && addr < 26'(pwc_pkg::BOUND_DEPTH))
      low_mem[addr] <= value[19:0];
    if (take && op == pwc_pkg::OP_HIGH && addr < 26'(pwc_pkg::BOUND_DEPTH))
      high_mem[addr] <= value[19:0];
    if (take && op == pwc_pkg::OP_WEIGHT && addr < 26'(pwc_pkg::WEIGHT_DEPTH))
      wt_mem[addr[12:0]] <= weight;
    if (take && op == pwc_pkg::OP_MAP && addr < 26'(pwc_pkg::MAP_DEPTH))
      map_mem[addr[6:0]] <= value[4:0];
    map_rd  <= map_mem[value[6:0]];
    low_rd  <= low_mem[hex_index < 26'(pwc_pkg::BOUND_DEPTH) ? hex_index : 26'd0];
    high_rd <= high_mem[hex_index < 26'(pwc_pkg::BOUND_DEPTH) ? hex_index : 26'd0];
    word_rd <= word_rok ? word_mem[word_raddr[TW_BITS-1:0]] : 60'd0;
    wt_rd   <= wt_rok ? wt_mem[wt_raddr] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid    <= '0;
      map_rd_valid <= 1'b0;
    end else begin
      if (take && op == pwc_pkg::OP_MAP && addr < 26'(pwc_pkg::MAP_DEPTH))
        map_valid[addr[6:0]] <= 1'b1;
      map_rd_valid <= map_valid[value[6:0]];
    end
  end

  logic [4:0]  amino;
  logic [4:0]  vc_next;
  logic [4:0]  drop, nxt;
  logic [25:0] hex_prod;
  assign amino = (map_oob || !map_rd_valid) ? pwc_pkg::MAP_INVALID : map_rd;
  assign vc_next = (valid_count < 5'(pwc_pkg::WINDOW)) ? valid_count + 5'd1 : valid_count;
  assign drop = hex_word[29:25];
  assign nxt  = recent_word[59:55];
  assign hex_prod = (hex_index - 26'(drop * 26'(pwc_pkg::HEX_SPAN))) * 26'd20 + 26'(nxt);

  logic signed [19:0] wsum_ext;
  assign wsum_ext = 20'(wt_rd);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pwc_pkg::ST_IDLE;
      recent_word    <= '0;
      hex_word       <= '0;
      hex_index      <= '0;
      valid_count    <= '0;
      letter_counter <= '0;
      strobe         <= 1'b0;
      last           <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        pwc_pkg::ST_IDLE: begin
          if (take && op == pwc_pkg::OP_LETTER) begin
            word_start     <= letter_counter - 32'(pwc_pkg::WINDOW - 1);
            letter_counter <= letter_counter + 32'd1;
            map_oob        <= (value >= 60'(pwc_pkg::MAP_DEPTH));
            state          <= pwc_pkg::ST_MAP;
          end
        end
        pwc_pkg::ST_MAP: begin
          if (amino >= 5'(pwc_pkg::ALPHA)) begin
            recent_word <= '0;
            hex_word    <= '0;
            hex_index   <= '0;
            valid_count <= '0;
            state       <= pwc_pkg::ST_IDLE;
          end else begin
            valid_count <= vc_next;
            if (vc_next > 5'(pwc_pkg::WORD_LETTERS)) begin
              hex_word  <= {hex_word[24:0], nxt};
              hex_index <= hex_prod;
            end
            recent_word <= {recent_word[54:0], amino};
            state <= (vc_next < 5'(pwc_pkg::WINDOW)) ? pwc_pkg::ST_IDLE
                                                     : pwc_pkg::ST_BOUND;
          end
        end
        pwc_pkg::ST_BOUND: state <= pwc_pkg::ST_BWAIT;
        pwc_pkg::ST_BWAIT: begin
          lo    <= (hex_index < 26'(pwc_pkg::BOUND_DEPTH)) ? low_rd : 20'd0;
          up    <= (hex_index < 26'(pwc_pkg::BOUND_DEPTH)) ? high_rd : 20'd0;
          state <= pwc_pkg::ST_PROBE;
        end
        pwc_pkg::ST_PROBE: begin
          if ({1'b0, up} > {1'b0, lo} + 21'd1) state <= pwc_pkg::ST_PWAIT;
          else begin
            which <= 1'b0;
            state <= pwc_pkg::ST_WORDS;
          end
        end
        pwc_pkg::ST_PWAIT: begin
          if (recent_word < word_rd) up <= piv;
          else if (recent_word > word_rd) lo <= piv;
          else begin
            lo <= piv;
            up <= piv;
          end
          state <= pwc_pkg::ST_PROBE;
        end
        pwc_pkg::ST_WORDS: state <= pwc_pkg::ST_WWAIT;
        pwc_pkg::ST_WWAIT: begin
          if (which) up_word <= word_rd;
          else       lo_word <= word_rd;
          if (which) begin
            which  <= 1'b0;
            pidx   <= '0;
            lo_sum <= '0;
            up_sum <= '0;
            state  <= pwc_pkg::ST_SCORE;
          end else begin
            which <= 1'b1;
            state <= pwc_pkg::ST_WORDS;
          end
        end
        pwc_pkg::ST_SCORE: state <= pwc_pkg::ST_SWAIT;
        pwc_pkg::ST_SWAIT: begin
          if (which) begin
            up_w[pidx] <= wt_rd;
            up_sum     <= up_sum + wsum_ext;
          end else begin
            lo_w[pidx] <= wt_rd;
            lo_sum     <= lo_sum + wsum_ext;
          end
          if (pidx == 4'(pwc_pkg::WORD_LETTERS - 1)) begin
            pidx <= '0;
            if (which) state <= pwc_pkg::ST_EMIT;
            else begin
              which <= 1'b1;
              state <= pwc_pkg::ST_SCORE;
            end
          end else begin
            pidx  <= pidx + 4'd1;
            state <= pwc_pkg::ST_SCORE;
          end
        end
        pwc_pkg::ST_EMIT: begin
          strobe      <= 1'b1;
          seq_pos     <= word_start;
          match_index <= win_up ? up : lo;
          total_score <= win_up ? up_sum : lo_sum;
          position    <= pidx;
          pos_score   <= win_up ? up_w[pidx] : lo_w[pidx];
          if (pidx == 4'(pwc_pkg::WORD_LETTERS - 1)) begin
            last  <= 1'b1;
            state <= pwc_pkg::ST_IDLE;
          end else pidx <= pidx + 4'd1;
        end
        default: state <= pwc_pkg::ST_IDLE;
      endcase
    end
  end

  assign win_up = (up_sum >= lo_sum);

  // Checks.
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe) else $error("last without strobe");
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    last |-> position == 4'(pwc_pkg::WORD_LETTERS - 1)) else $error("last misplaced");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy) else $error("result stream broken");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");

endmodule
